[hdl/text_console_cell_writer_macros.svh]
// Assertion macros for the text console cell writer.
// Expects signals named clock and reset in the module that uses them.
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TCW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check that a condition is followed in the next cycle by another.
`define TCW_ASSERT_NEXT(label, cond, nxt, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error(msg);

`endif

[hdl/tcw_pkg.sv]
// Shared types and constants for the text console cell writer.
// No dependencies.
package tcw_pkg;

   typedef logic [15:0] cell_type;
   typedef logic [2:0]  action_type;

   localparam action_type ACT_PUT_CHAR   = 3'd0;
   localparam action_type ACT_PUT_AT     = 3'd1;
   localparam action_type ACT_MOVE       = 3'd2;
   localparam action_type ACT_SET        = 3'd3;
   localparam action_type ACT_CLEAR      = 3'd4;
   localparam action_type ACT_CLEAR_LINE = 3'd5;
   localparam action_type ACT_READ       = 3'd6;
   localparam action_type ACT_NOP        = 3'd7;

   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   localparam cell_type RESET_CELL = 16'h0F20;

   localparam logic CSR_TEXT_COLOR = 1'b0;
   localparam logic CSR_BACK_COLOR = 1'b1;

   localparam int REQ_W = 56;
   localparam int RSP_W = 40;

endpackage

[hdl/tcw_cell_store.sv]
// Single-port text cell memory with registered read data.
// Depends on tcw_pkg for the cell type.
module tcw_cell_store #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic             rd_en,
   input  logic [AW-1:0]    addr,
   input  tcw_pkg::cell_type wr_data,
   output tcw_pkg::cell_type rd_data
);
   import tcw_pkg::*;

   cell_type mem [DEPTH];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/text_console_cell_writer.sv]
// Text console cell writer: cursor sequencer, shared address unit and cell store.
// Depends on tcw_pkg, tcw_cell_store and text_console_cell_writer_macros.svh.
//
// The block holds a COLUMNS x ROWS store of 16-bit text cells (character in
// bits 7..0, attribute in bits 15..8) and a cursor, and runs one action per
// request transfer, answering with exactly one response transfer that carries
// the cursor, its linear position and, for a read, the cell. After reset the
// block sweeps the store to blank white-on-black cells, one cell per cycle,
// so req_tready stays low until that sweep ends; csr writes are taken at
// all times. One action is handled at a time. A cursor-only action passes
// through the execute and done states, a cell write adds a one-cell store
// sweep, a read adds a store read state, and clear line and clear sweep the
// line or the whole store through the single store port, one cell per cycle.
// A single multiply-add unit (row*COLUMNS+col) serves every start address of
// an action but the zero start of a full clear, and also the reported
// linear position. A finished response waits in the output register while
// the next request is taken; while that register is still held by the
// receiver, the next finished action waits in its last cycle and the
// request side stays stalled.
module text_console_cell_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                      clock,
   input  logic                      reset,
   // fields from bit 0: action[2:0], char_code[10:3], cell_color[18:11],
   // col[26:19], row[34:27], dx[42:35], dy[50:43], zero pad[55:51]
   input  logic [tcw_pkg::REQ_W-1:0] req_tdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // fields from bit 0: cursor_col[6:0], cursor_row[11:7],
   // cursor_linear[22:12], cell_data[38:23], zero pad[39]
   output logic [tcw_pkg::RSP_W-1:0] rsp_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_index,
   input  logic [3:0]                csr_data
);
   import tcw_pkg::*;

   `include "text_console_cell_writer_macros.svh"

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_SWEEP = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   // Sequencer and cursor state
   logic [2:0]   state_ff, state_in;
   logic [6:0]   cursor_col_ff, cursor_col_in;
   logic [4:0]   cursor_row_ff, cursor_row_in;
   logic [3:0]   text_color_ff, back_color_ff;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] last_ff, last_in;
   cell_type     wdata_ff, wdata_in;
   logic         read_hit_ff, read_hit_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic [50:0]  item_ff;

   // Item fields
   action_type   f_action;
   logic [7:0]   f_char, f_color, f_col, f_row, f_dx, f_dy;

   // Shared address unit
   logic [4:0]   unit_row;
   logic [6:0]   unit_col;
   logic [AW-1:0] unit_addr;

   logic         in_bounds;
   logic [4:0]   row_adv;
   logic [7:0]   col_plus;
   logic signed [9:0] mv_col_s, mv_row_s;
   logic [7:0]   attr;
   logic         store_wr, store_rd;
   cell_type     store_rdata;
   logic         load_rsp;

   assign f_action = item_ff[2:0];
   assign f_char   = item_ff[10:3];
   assign f_color  = item_ff[18:11];
   assign f_col    = item_ff[26:19];
   assign f_row    = item_ff[34:27];
   assign f_dx     = item_ff[42:35];
   assign f_dy     = item_ff[50:43];

   assign attr      = {back_color_ff, text_color_ff};
   assign in_bounds = (f_col < 8'(COLUMNS)) && (f_row < 8'(ROWS));
   assign row_adv   = (cursor_row_ff == 5'(ROWS - 1)) ? 5'd0 : cursor_row_ff + 5'd1;
   assign col_plus  = {1'b0, cursor_col_ff} + 8'd1;
   assign mv_col_s  = $signed({3'b000, cursor_col_ff}) + $signed({{2{f_dx[7]}}, f_dx});
   assign mv_row_s  = $signed({5'b00000, cursor_row_ff}) + $signed({{2{f_dy[7]}}, f_dy});

   // Operand select for the multiply-add unit: item cell, cursor cell, cursor
   // row start for clear line or the cell left of the cursor for backspace.
   always_comb begin
      unit_row = cursor_row_ff;
      unit_col = cursor_col_ff;
      if (state_ff == S_EXEC) begin
         case (f_action) inside
            ACT_PUT_AT, ACT_READ: begin
               unit_row = f_row[4:0];
               unit_col = f_col[6:0];
            end
            ACT_PUT_CHAR: begin
               if (f_char == CH_BACKSPACE) begin
                  unit_col = cursor_col_ff - 7'd1;
               end
            end
            ACT_CLEAR_LINE: begin
               unit_col = 7'd0;
            end
            default: begin
               unit_col = cursor_col_ff;
            end
         endcase
      end
   end

   assign unit_addr = AW'(unit_row) * AW'(COLUMNS) + AW'(unit_col);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      addr_in       = addr_ff;
      last_in       = last_ff;
      wdata_in      = wdata_ff;
      read_hit_in   = read_hit_ff;
      load_rsp      = 1'b0;

      unique case (state_ff)
         S_INIT, S_SWEEP: begin
            // advance one cell per cycle until the last one is written
            if (addr_ff == last_ff) begin
               state_in = (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in    = S_DONE;
            read_hit_in = 1'b0;
            addr_in     = unit_addr;
            last_in     = unit_addr;
            unique case (f_action)
               ACT_PUT_CHAR: begin
                  if (f_char == CH_BACKSPACE) begin
                     if (cursor_col_ff != 7'd0) begin
                        cursor_col_in = cursor_col_ff - 7'd1;
                        wdata_in      = {attr, CH_SPACE};
                        state_in      = S_SWEEP;
                     end
                  end else if (f_char == CH_NEWLINE) begin
                     cursor_col_in = 7'd0;
                     cursor_row_in = row_adv;
                  end else begin
                     wdata_in = {attr, f_char};
                     state_in = S_SWEEP;
                     if (col_plus == 8'(COLUMNS)) begin
                        cursor_col_in = 7'd0;
                        cursor_row_in = row_adv;
                     end else begin
                        cursor_col_in = col_plus[6:0];
                     end
                  end
               end
               ACT_PUT_AT: begin
                  wdata_in = {f_color, f_char};
                  if (in_bounds) begin
                     state_in = S_SWEEP;
                  end
               end
               ACT_MOVE: begin
                  if (mv_col_s < 10'sd0) begin
                     cursor_col_in = 7'd0;
                  end else if (mv_col_s > $signed(10'(COLUMNS - 1))) begin
                     cursor_col_in = 7'(COLUMNS - 1);
                  end else begin
                     cursor_col_in = mv_col_s[6:0];
                  end
                  if (mv_row_s < 10'sd0) begin
                     cursor_row_in = 5'd0;
                  end else if (mv_row_s > $signed(10'(ROWS - 1))) begin
                     cursor_row_in = 5'(ROWS - 1);
                  end else begin
                     cursor_row_in = mv_row_s[4:0];
                  end
               end
               ACT_SET: begin
                  cursor_col_in = (f_col < 8'(COLUMNS)) ? f_col[6:0] : 7'(COLUMNS - 1);
                  cursor_row_in = (f_row < 8'(ROWS)) ? f_row[4:0] : 5'(ROWS - 1);
               end
               ACT_CLEAR: begin
                  addr_in       = '0;
                  last_in       = AW'(CELLS - 1);
                  wdata_in      = {attr, CH_SPACE};
                  cursor_col_in = 7'd0;
                  cursor_row_in = 5'd0;
                  state_in      = S_SWEEP;
               end
               ACT_CLEAR_LINE: begin
                  last_in       = unit_addr + AW'(COLUMNS - 1);
                  wdata_in      = {attr, CH_SPACE};
                  cursor_col_in = 7'd0;
                  state_in      = S_SWEEP;
               end
               ACT_READ: begin
                  if (in_bounds) begin
                     read_hit_in = 1'b1;
                     state_in    = S_READ;
                  end
               end
               ACT_NOP: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_READ: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response: the unit is idle in S_DONE and forms the linear position.
   assign rsp_data_in = {1'b0,
                         read_hit_ff ? store_rdata : 16'h0000,
                         11'(unit_addr),
                         cursor_row_ff,
                         cursor_col_ff};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         cursor_col_ff <= 7'd0;
         cursor_row_ff <= 5'd0;
         text_color_ff <= 4'hF;
         back_color_ff <= 4'h0;
         addr_ff       <= '0;
         last_ff       <= AW'(CELLS - 1);
         wdata_ff      <= RESET_CELL;
         read_hit_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         addr_ff       <= addr_in;
         last_ff       <= last_in;
         wdata_ff      <= wdata_in;
         read_hit_ff   <= read_hit_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_TEXT_COLOR: text_color_ff <= csr_data;
               CSR_BACK_COLOR: back_color_ff <= csr_data;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_tdata[50:0];
      end
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign store_wr = (state_ff == S_INIT) || (state_ff == S_SWEEP);
   assign store_rd = (state_ff == S_READ);

   tcw_cell_store #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .rd_en   (store_rd),
      .addr    (addr_ff),
      .wr_data (wdata_ff),
      .rd_data (store_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   `TCW_ASSERT(a_cursor_on_screen, ({1'b0, cursor_col_ff} < 8'(COLUMNS)) && (cursor_row_ff < 5'(ROWS - 1) || cursor_row_ff == 5'(ROWS - 1)), "cursor left the screen")
   `TCW_ASSERT(a_sweep_in_range, (state_ff == S_SWEEP || state_ff == S_INIT) |-> (addr_ff <= last_ff), "store sweep ran past its last cell")
   `TCW_ASSERT_NEXT(a_accept_starts_exec, req_tvalid && req_tready, state_ff == S_EXEC, "accepted request did not start execution")

endmodule

[tb/text_console_cell_writer_test.sv]
// Self-checking testbench for the text console cell writer: directed and random
// console actions through the request stream, checked against an in-bench console model.
// Depends on tcw_pkg and text_console_cell_writer.
`timescale 1ns / 1ps

module text_console_cell_writer_test;
   import tcw_pkg::*;

   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int CELLS       = COLUMNS * ROWS;
   // A full clear sweeps all CELLS cells. Even if every transfer were a clear
   // with stalls on both sides, the run stays well below this bound.
   localparam int LIMIT       = 12_000_000;
   localparam int HOLD_CYCLES = 400;
   localparam int MAX_REPORTS = 40;

   // One console action as it travels on req_tdata.
   typedef struct {
      action_type        action;
      logic [7:0]        char_code;
      logic [7:0]        cell_color;
      logic [7:0]        col;
      logic [7:0]        row;
      logic signed [7:0] dx;
      logic signed [7:0] dy;
   } console_req_type;

   // What the block reports back for one action.
   typedef struct {
      logic [6:0]  col;
      logic [4:0]  row;
      logic [10:0] linear;
      cell_type    data;
   } cursor_report_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic             csr_index  = CSR_TEXT_COLOR;
   logic [3:0]       csr_data   = '0;

   // Console model: screen contents, cursor and current colors.
   cell_type screen [CELLS];
   int       cursor_x;
   int       cursor_y;
   logic [3:0] fg_color;
   logic [3:0] bg_color;

   // Reports still owed by the block, oldest first.
   cursor_report_type cursor_reports [$];

   int  mismatches     = 0;
   int  reports_seen   = 0;
   int  color_writes   = 0;
   int  action_count [8];
   int  cycle_count    = 0;
   int  last_put_col   = 0;
   int  last_put_row   = 0;
   // No-idle mode for both sides of the stream.
   logic steady        = 1'b0;
   // Long receiver hold-offs: the test asks, the receiver process serves.
   int  hold_requests  = 0;
   int  holds_served   = 0;
   int  hold_left      = 0;

   text_console_cell_writer #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Console model
   // ---------------------------------------------------------------------

   function automatic int clamp_to(int v, int hi);
      if (v < 0)
         return 0;
      if (v > hi)
         return hi;
      return v;
   endfunction

   // Step down one row, wrapping from the bottom row to the top (no scroll).
   function automatic void advance_line();
      cursor_y = (cursor_y == ROWS - 1) ? 0 : cursor_y + 1;
   endfunction

   // Apply one action to the model and return the report it should produce.
   function automatic cursor_report_type apply_console_action(console_req_type r);
      cursor_report_type rep;
      cell_type          blank;
      blank    = {bg_color, fg_color, CH_SPACE};
      rep.data = '0;
      case (r.action)
         ACT_PUT_CHAR: begin
            if (r.char_code == CH_BACKSPACE) begin
               // Backspace at column zero leaves everything alone.
               if (cursor_x > 0) begin
                  cursor_x--;
                  screen[cursor_y * COLUMNS + cursor_x] = blank;
               end
            end else if (r.char_code == CH_NEWLINE) begin
               cursor_x = 0;
               advance_line();
            end else begin
               screen[cursor_y * COLUMNS + cursor_x] = {bg_color, fg_color, r.char_code};
               cursor_x++;
               if (cursor_x >= COLUMNS) begin
                  cursor_x = 0;
                  advance_line();
               end
            end
         end
         ACT_PUT_AT: begin
            // Off-screen targets are dropped.
            if (r.col < COLUMNS && r.row < ROWS)
               screen[r.row * COLUMNS + r.col] = {r.cell_color, r.char_code};
         end
         ACT_MOVE: begin
            cursor_x = clamp_to(cursor_x + int'(r.dx), COLUMNS - 1);
            cursor_y = clamp_to(cursor_y + int'(r.dy), ROWS - 1);
         end
         ACT_SET: begin
            cursor_x = (r.col < COLUMNS) ? int'(r.col) : COLUMNS - 1;
            cursor_y = (r.row < ROWS) ? int'(r.row) : ROWS - 1;
         end
         ACT_CLEAR: begin
            foreach (screen[i])
               screen[i] = blank;
            cursor_x = 0;
            cursor_y = 0;
         end
         ACT_CLEAR_LINE: begin
            for (int i = 0; i < COLUMNS; i++)
               screen[cursor_y * COLUMNS + i] = blank;
            cursor_x = 0;
         end
         ACT_READ: begin
            if (r.col < COLUMNS && r.row < ROWS)
               rep.data = screen[r.row * COLUMNS + r.col];
         end
         default: ;
      endcase
      rep.col    = 7'(cursor_x);
      rep.row    = 5'(cursor_y);
      rep.linear = 11'(cursor_y * COLUMNS + cursor_x);
      return rep;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Mostly well-formed actions on the visible screen; a share of the put-at,
   // move, set and read actions goes off-screen or uses full-range offsets.
   function automatic console_req_type random_request();
      console_req_type r;
      int              pick;
      int              sub;
      r.action     = ACT_NOP;
      r.char_code  = 8'($urandom_range(0, 255));
      r.cell_color = 8'($urandom_range(0, 255));
      r.col        = 8'($urandom_range(0, 255));
      r.row        = 8'($urandom_range(0, 255));
      r.dx         = 8'($urandom_range(0, 255));
      r.dy         = 8'($urandom_range(0, 255));
      pick         = $urandom_range(0, 99);
      sub          = $urandom_range(0, 9);
      if (pick < 36) begin
         r.action = ACT_PUT_CHAR;
         if (sub == 0)
            r.char_code = CH_BACKSPACE;
         else if (sub == 1)
            r.char_code = CH_NEWLINE;
      end else if (pick < 50) begin
         r.action = ACT_PUT_AT;
         if (sub >= 2) begin
            r.col = 8'($urandom_range(0, COLUMNS - 1));
            r.row = 8'($urandom_range(0, ROWS - 1));
         end
         last_put_col = r.col;
         last_put_row = r.row;
      end else if (pick < 60) begin
         r.action = ACT_MOVE;
         if (sub >= 3) begin
            r.dx = 8'($urandom_range(0, 6) - 3);
            r.dy = 8'($urandom_range(0, 6) - 3);
         end
      end else if (pick < 68) begin
         r.action = ACT_SET;
         if (sub >= 3) begin
            r.col = 8'($urandom_range(0, COLUMNS - 1));
            r.row = 8'($urandom_range(0, ROWS - 1));
         end
      end else if (pick < 69) begin
         r.action = ACT_CLEAR;
      end else if (pick < 72) begin
         r.action = ACT_CLEAR_LINE;
      end else if (pick < 96) begin
         r.action = ACT_READ;
         // Aim most reads at cells that were just written, so stores show up.
         if (sub < 4) begin
            r.col = 8'((cursor_x > 0) ? cursor_x - 1 : 0);
            r.row = 8'(cursor_y);
         end else if (sub < 6) begin
            r.col = 8'(last_put_col);
            r.row = 8'(last_put_row);
         end else if (sub < 9) begin
            r.col = 8'($urandom_range(0, COLUMNS - 1));
            r.row = 8'($urandom_range(0, ROWS - 1));
         end
      end
      return r;
   endfunction

   // Offer one action, hold it until the transfer, then record what it owes.
   task automatic send_request(input console_req_type r);
      if (!steady && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 15);
      end
      req_tdata  <= {5'd0, r.dy, r.dx, r.row, r.col, r.cell_color, r.char_code, r.action};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      cursor_reports.push_back(apply_console_action(r));
      action_count[r.action]++;
   endtask

   task automatic issue(input action_type a, input logic [7:0] ch, input logic [7:0] color,
                        input logic [7:0] c, input logic [7:0] rw,
                        input logic signed [7:0] dx = 0, input logic signed [7:0] dy = 0);
      console_req_type r;
      r = '{a, ch, color, c, rw, dx, dy};
      send_request(r);
   endtask

   // Drop valid and wait until every owed report has come back.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (cursor_reports.size() != 0);
   endtask

   // Write both color registers back to back; call only while the block is idle.
   task automatic set_colors(input logic [3:0] text_value, input logic [3:0] back_value);
      for (int k = 0; k < 2; k++) begin
         csr_index <= (k == 0) ? CSR_TEXT_COLOR : CSR_BACK_COLOR;
         csr_data  <= (k == 0) ? text_value : back_value;
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
         if (k == 0)
            fg_color = text_value;
         else
            bg_color = back_value;
         color_writes++;
      end
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Characters at the cursor: raw bytes, backspace, newline, wrap at the end.
   task automatic test_cursor_writes();
      set_colors(4'd10, 4'd1);
      issue(ACT_PUT_CHAR, 8'h41, 8'h00, 8'd0, 8'd0);
      issue(ACT_PUT_CHAR, 8'h00, 8'h00, 8'd0, 8'd0);
      issue(ACT_PUT_CHAR, 8'hFF, 8'h00, 8'd0, 8'd0);
      issue(ACT_PUT_CHAR, CH_BACKSPACE, 8'h00, 8'd0, 8'd0);
      issue(ACT_READ, 8'h00, 8'h00, 8'd2, 8'd0);
      issue(ACT_PUT_CHAR, CH_NEWLINE, 8'h00, 8'd0, 8'd0);
      // backspace in column zero must not touch anything
      issue(ACT_PUT_CHAR, CH_BACKSPACE, 8'h00, 8'd0, 8'd0);
      // last cell of the screen wraps the cursor to the top-left corner
      issue(ACT_SET, 8'h00, 8'h00, 8'd79, 8'd24);
      issue(ACT_PUT_CHAR, 8'h5A, 8'h00, 8'd0, 8'd0);
      issue(ACT_SET, 8'h00, 8'h00, 8'd0, 8'd24);
      issue(ACT_PUT_CHAR, CH_NEWLINE, 8'h00, 8'd0, 8'd0);
   endtask

   // Saturating set and clamping relative moves at both extremes.
   task automatic test_cursor_positioning();
      issue(ACT_SET, 8'h00, 8'h00, 8'd255, 8'd255);
      issue(ACT_SET, 8'h00, 8'h00, 8'd80, 8'd25);
      issue(ACT_MOVE, 8'h00, 8'h00, 8'd0, 8'd0, 8'sh80, 8'sh80);
      issue(ACT_MOVE, 8'h00, 8'h00, 8'd0, 8'd0, 8'sh7F, 8'sh7F);
   endtask

   // Direct cell writes with their own attribute, off-screen drops, reads.
   task automatic test_direct_cells();
      issue(ACT_PUT_AT, 8'h00, 8'hFF, 8'd79, 8'd24);
      issue(ACT_PUT_AT, 8'hFF, 8'h00, 8'd0, 8'd0);
      issue(ACT_PUT_AT, 8'h41, 8'h5A, 8'd80, 8'd0);
      issue(ACT_PUT_AT, 8'h41, 8'h5A, 8'd0, 8'd25);
      issue(ACT_READ, 8'h00, 8'h00, 8'd79, 8'd24);
      issue(ACT_READ, 8'h00, 8'h00, 8'd80, 8'd24);
      issue(ACT_READ, 8'h00, 8'h00, 8'd255, 8'd255);
      // the spare action code only reports the cursor
      issue(ACT_NOP, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'shFF, 8'shFF);
   endtask

   // Line and screen clears in a non-default attribute.
   task automatic test_clears();
      drain_responses();
      set_colors(4'd0, 4'd15);
      issue(ACT_SET, 8'h00, 8'h00, 8'd40, 8'd12);
      issue(ACT_CLEAR_LINE, 8'h00, 8'h00, 8'd0, 8'd0);
      issue(ACT_READ, 8'h00, 8'h00, 8'd79, 8'd12);
      issue(ACT_CLEAR, 8'h00, 8'h00, 8'd0, 8'd0);
      issue(ACT_READ, 8'h00, 8'h00, 8'd79, 8'd24);
   endtask

   // Hold the receiver off for a long stretch while actions keep coming,
   // so the output register fills and the block stalls its request side.
   task automatic test_output_backpressure();
      hold_requests <= hold_requests + 1;
      repeat (30)
         send_request(random_request());
   endtask

   // Random traffic in phases, each with its own colors; one phase runs
   // without any idle cycles on either side.
   task automatic test_random_traffic();
      logic [3:0] text_sel [5];
      logic [3:0] back_sel [5];
      text_sel = '{4'd15, 4'd0, 4'd15, 4'($urandom_range(0, 15)), 4'd0};
      back_sel = '{4'd15, 4'd0, 4'd0, 4'($urandom_range(0, 15)), 4'd15};
      for (int p = 0; p < 5; p++) begin
         drain_responses();
         set_colors(text_sel[p], back_sel[p]);
         steady <= (p == 2);
         repeat (200)
            send_request(random_request());
      end
      steady <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Receiver and checker
   // ---------------------------------------------------------------------

   // Drive rsp_tready: serve long hold-offs, else stall at random.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 15);
      end
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // Compare every response transfer with the oldest owed report.
   always @(posedge clock) begin : check_reports
      cursor_report_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cursor_reports.size() == 0) begin
            mismatches++;
            $display("%0t: response with nothing owed, actual data %h", $time, rsp_tdata);
         end else begin
            due = cursor_reports.pop_front();
            check_field("cursor_col", due.col, rsp_tdata[6:0]);
            check_field("cursor_row", due.row, rsp_tdata[11:7]);
            check_field("cursor_linear", due.linear, rsp_tdata[22:12]);
            check_field("cell_data", due.data, rsp_tdata[38:23]);
            reports_seen++;
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d reports still owed",
                  $time, cycle_count, cursor_reports.size());
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      foreach (screen[i])
         screen[i] = RESET_CELL;
      cursor_x = 0;
      cursor_y = 0;
      fg_color = 4'd15;
      bg_color = 4'd0;
      foreach (action_count[i])
         action_count[i] = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_cursor_writes();
      test_cursor_positioning();
      test_direct_cells();
      test_clears();
      test_output_backpressure();
      test_random_traffic();

      drain_responses();
      repeat (20) @(posedge clock);

      $display("Ran %0d actions: put char %0d, put at %0d, move %0d, set %0d, clear %0d,",
               reports_seen, action_count[ACT_PUT_CHAR], action_count[ACT_PUT_AT],
               action_count[ACT_MOVE], action_count[ACT_SET], action_count[ACT_CLEAR]);
      $display("clear line %0d, read %0d, spare %0d; %0d color writes, %0d mismatches",
               action_count[ACT_CLEAR_LINE], action_count[ACT_READ], action_count[ACT_NOP],
               color_writes, mismatches);
      if (mismatches == 0 && cursor_reports.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
